// ===== hw/rtl/lpts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpts_pkg;

	localparam int SPRITE_SLOTS = 10;
	localparam int LINE_WIDTH   = 160;
	localparam int SLOT_IDX_W   = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;

	localparam logic [15:0] MAP_BASE_LO   = 16'h9800;
	localparam logic [15:0] MAP_BASE_HI   = 16'h9C00;
	localparam logic [15:0] TDATA_UNSIGNED = 16'h8000;
	localparam logic [15:0] TDATA_SIGNED   = 16'h8800;
	localparam logic [4:0]  FIFO_MIN      = 5'd8;
	localparam logic [7:0]  WX_OFFSET     = 8'd7;
	localparam logic [8:0]  OBJ_X_OFFSET  = 9'd8;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ACT_WAIT    = 3'd0,
		ACT_DROP    = 3'd1,
		ACT_PIXEL   = 3'd2,
		ACT_FETCH   = 3'd3,
		ACT_SPRITE  = 3'd4,
		ACT_DISABLE = 3'd5
	} act_t;

	typedef enum logic [2:0] {
		CFG_LCDC   = 3'd0,
		CFG_SCX    = 3'd1,
		CFG_SCY    = 3'd2,
		CFG_WY     = 3'd3,
		CFG_WX     = 3'd4,
		CFG_COLOUR = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] lcdc_flags;
		logic [7:0] scroll_x;
		logic [7:0] scroll_y;
		logic [7:0] window_y;
		logic [7:0] window_x;
		logic       colour_mode;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  slot;
		logic [7:0]  obj_x;
		logic [15:0] obj_addr;
		logic [7:0]  line;
		logic [4:0]  fifo_count;
		logic        sprite_fetch_busy;
	} in_item_t;

	typedef struct packed {
		logic        line_active;
		act_t        action;
		logic [15:0] map_row_addr;
		logic [15:0] tile_data_base;
		logic [4:0]  tile_col;
		logic [2:0]  tile_row;
		logic        signed_tiles;
		logic [3:0]  sprite_slot;
		logic [3:0]  sprite_skip;
		logic [15:0] sprite_addr;
	} out_item_t;

	typedef struct packed {
		logic        en;
		logic [3:0]  slot;
		logic [7:0]  x;
		logic [15:0] addr;
	} sprite_load_t;

	typedef struct packed {
		logic        hit;
		logic [3:0]  slot;
		logic [3:0]  skip;
		logic [15:0] addr;
	} sprite_hit_t;

	// Tile fetch command: map row from the map select, pixel row within tile.
	function automatic out_item_t make_fetch(logic map_hi, logic [7:0] row, logic [4:0] col,
			logic unsigned_tiles);
		out_item_t r;
		r = '0;
		r.line_active    = 1'b1;
		r.action         = ACT_FETCH;
		r.map_row_addr   = (map_hi ? MAP_BASE_HI : MAP_BASE_LO) + {6'd0, row[7:3], 5'd0};
		r.tile_data_base = unsigned_tiles ? TDATA_UNSIGNED : TDATA_SIGNED;
		r.signed_tiles   = ~unsigned_tiles;
		r.tile_col       = col;
		r.tile_row       = row[2:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lpts_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lpts_stream_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lpts_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpts_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [7:0]   cfg_wdata,
	output lpts_pkg::cfg_t    cfg
);

	lpts_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lcdc_flags  <= 8'h91;
			cfg_q.scroll_x    <= '0;
			cfg_q.scroll_y    <= '0;
			cfg_q.window_y    <= '0;
			cfg_q.window_x    <= '0;
			cfg_q.colour_mode <= 1'b0;
		end else if (cfg_we) begin
			unique case (lpts_pkg::cfg_idx_t'(cfg_index))
				lpts_pkg::CFG_LCDC:   cfg_q.lcdc_flags  <= cfg_wdata;
				lpts_pkg::CFG_SCX:    cfg_q.scroll_x    <= cfg_wdata;
				lpts_pkg::CFG_SCY:    cfg_q.scroll_y    <= cfg_wdata;
				lpts_pkg::CFG_WY:     cfg_q.window_y    <= cfg_wdata;
				lpts_pkg::CFG_WX:     cfg_q.window_x    <= cfg_wdata;
				lpts_pkg::CFG_COLOUR: cfg_q.colour_mode <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lpts_sprite_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpts_sprite_table (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire lpts_pkg::sprite_load_t load,
	input  wire logic                   clr_en,
	input  wire logic [7:0]             pixel_x,
	output lpts_pkg::sprite_hit_t       hit
);

	logic [7:0]  slot_x_q    [lpts_pkg::SPRITE_SLOTS];
	logic [15:0] slot_addr_q [lpts_pkg::SPRITE_SLOTS];
	logic [lpts_pkg::SPRITE_SLOTS-1:0] match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lpts_pkg::SPRITE_SLOTS; i++) begin
				slot_x_q[i]    <= '0;
				slot_addr_q[i] <= '0;
			end
		end else if (load.en) begin
			slot_x_q[load.slot[lpts_pkg::SLOT_IDX_W-1:0]]    <= load.x;
			slot_addr_q[load.slot[lpts_pkg::SLOT_IDX_W-1:0]] <= load.addr;
		end else if (clr_en) begin
			// empty only the slot that won the pick
			slot_x_q[hit.slot[lpts_pkg::SLOT_IDX_W-1:0]]    <= '0;
			slot_addr_q[hit.slot[lpts_pkg::SLOT_IDX_W-1:0]] <= '0;
		end
	end

	always_comb begin
		for (int i = 0; i < lpts_pkg::SPRITE_SLOTS; i++) begin
			match[i] = (slot_addr_q[i] != 16'd0) &&
				(((pixel_x == 8'd0) && (slot_x_q[i] < 8'd8)) ||
				({1'b0, slot_x_q[i]} == ({1'b0, pixel_x} + lpts_pkg::OBJ_X_OFFSET)));
		end
	end

	// priority pick: walk down so the lowest matching slot lands last
	always_comb begin
		hit = '0;
		for (int i = lpts_pkg::SPRITE_SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit.hit  = 1'b1;
				hit.slot = 4'(i);
				hit.addr = slot_addr_q[i];
				hit.skip = (slot_x_q[i] < 8'd8) ? (4'd8 - {1'b0, slot_x_q[i][2:0]}) : 4'd0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lcd_pixel_transfer_sequencer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Port      Direction  Payload
// item      item      in         op, slot, obj_x, obj_addr, line, fifo_count, sprite_fetch_busy
// result    result    out        line_active, action, fetch fields, sprite fields
// config    cfg_*     in         write enable, register index, 8-bit data
//
// One item per cycle. An item sits in the input register, where the
// decision is made against the line state and the sprite slot compares, and
// its result goes to the output register. Loads and unused ops give no result.
// Reset clears the line state and empties every sprite slot at once.
// A stall on result holds the output register and backs up into item only
// when the input register also holds a result-producing item.

module lcd_pixel_transfer_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lpts_stream_if.sink      item,
	lpts_stream_if.source    result,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_wdata
);

	lpts_pkg::cfg_t         cfg;
	lpts_pkg::in_item_t     item_s1;
	logic                   valid_s1;
	lpts_pkg::out_item_t    res_q;
	logic                   res_valid_q;
	lpts_pkg::out_item_t    res_d;

	logic [7:0] pixel_x_q, pixel_x_d;
	logic [2:0] dropped_q, dropped_d;
	logic       window_on_q, window_on_d;
	logic [7:0] line_q, line_d;

	lpts_pkg::sprite_load_t load;
	lpts_pkg::sprite_hit_t  hit;
	logic                   sprite_take;

	logic has_result, out_free, adv_s1, bg_path, win_hit;
	logic [7:0] pixel_inc;

	lpts_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign has_result = (item_s1.op == lpts_pkg::OP_START) || (item_s1.op == lpts_pkg::OP_TICK);
	assign out_free   = !res_valid_q || result.ready;
	assign adv_s1     = valid_s1 && (!has_result || out_free);
	assign item.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	assign load.en   = adv_s1 && (item_s1.op == lpts_pkg::OP_LOAD) &&
		(item_s1.slot < 4'(lpts_pkg::SPRITE_SLOTS));
	assign load.slot = item_s1.slot;
	assign load.x    = item_s1.obj_x;
	assign load.addr = item_s1.obj_addr;

	lpts_sprite_table u_sprites (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.clr_en  (adv_s1 && sprite_take),
		.pixel_x (pixel_x_q),
		.hit     (hit)
	);

	assign bg_path   = cfg.colour_mode || cfg.lcdc_flags[0];
	assign pixel_inc = pixel_x_q + 8'd1;
	assign win_hit   = !window_on_q && cfg.lcdc_flags[5] && (line_q >= cfg.window_y) &&
		(cfg.window_x >= lpts_pkg::WX_OFFSET) &&
		(pixel_x_q == (cfg.window_x - lpts_pkg::WX_OFFSET));

	always_comb begin
		res_d             = '0;
		res_d.line_active = 1'b1;
		res_d.action      = lpts_pkg::ACT_WAIT;
		pixel_x_d         = pixel_x_q;
		dropped_d         = dropped_q;
		window_on_d       = window_on_q;
		line_d            = line_q;
		sprite_take       = 1'b0;
		if (item_s1.op == lpts_pkg::OP_START) begin
			line_d      = item_s1.line;
			pixel_x_d   = '0;
			dropped_d   = '0;
			window_on_d = 1'b0;
			if (bg_path) begin
				res_d = lpts_pkg::make_fetch(cfg.lcdc_flags[3], cfg.scroll_y + item_s1.line,
					cfg.scroll_x[7:3], cfg.lcdc_flags[4]);
			end else begin
				res_d.action = lpts_pkg::ACT_DISABLE;
			end
		end else if (item_s1.op == lpts_pkg::OP_TICK) begin
			if (pixel_x_q >= 8'(lpts_pkg::LINE_WIDTH)) begin
				res_d.line_active = 1'b0;
			end else if (bg_path && (item_s1.fifo_count <= lpts_pkg::FIFO_MIN)) begin
				res_d.action = lpts_pkg::ACT_WAIT;
			end else if (bg_path && (dropped_q < cfg.scroll_x[2:0])) begin
				dropped_d    = dropped_q + 3'd1;
				res_d.action = lpts_pkg::ACT_DROP;
			end else if (bg_path && win_hit) begin
				window_on_d = 1'b1;
				res_d = lpts_pkg::make_fetch(cfg.lcdc_flags[6], line_q - cfg.window_y, 5'd0,
					cfg.lcdc_flags[4]);
			end else if (bg_path && cfg.lcdc_flags[1] && item_s1.sprite_fetch_busy) begin
				res_d.action = lpts_pkg::ACT_WAIT;
			end else if (bg_path && cfg.lcdc_flags[1] && hit.hit) begin
				sprite_take       = 1'b1;
				res_d.action      = lpts_pkg::ACT_SPRITE;
				res_d.sprite_slot = hit.slot;
				res_d.sprite_skip = hit.skip;
				res_d.sprite_addr = hit.addr;
			end else begin
				pixel_x_d         = pixel_inc;
				res_d.action      = lpts_pkg::ACT_PIXEL;
				res_d.line_active = (pixel_inc != 8'(lpts_pkg::LINE_WIDTH));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_x_q   <= '0;
			dropped_q   <= '0;
			window_on_q <= 1'b0;
			line_q      <= '0;
		end else if (adv_s1) begin
			pixel_x_q   <= pixel_x_d;
			dropped_q   <= dropped_d;
			window_on_q <= window_on_d;
			line_q      <= line_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && has_result) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lpts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpts_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire lpts_pkg::out_item_t out_data
);

	// a stalled transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_sprite_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.action == lpts_pkg::ACT_SPRITE) |-> out_data.sprite_addr != 16'd0)
		else $error("sprite fetch from an empty slot");

	a_line_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.line_active |->
			(out_data.action == lpts_pkg::ACT_WAIT) || (out_data.action == lpts_pkg::ACT_PIXEL))
		else $error("line ended on a non-pixel action");

	a_fetch_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.action != lpts_pkg::ACT_FETCH) |->
			(out_data.map_row_addr == 16'd0) && (out_data.tile_data_base == 16'd0) &&
			(out_data.tile_col == 5'd0))
		else $error("fetch fields set outside a tile fetch");

endmodule

bind lcd_pixel_transfer_sequencer_unit lpts_checker u_lpts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

`default_nettype wire

// ===== test/lpts_result_checker.sv =====
`timescale 1ns / 1ps

module lpts_result_checker
	import lpts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      item_ready,
	input  in_item_t  item_data,
	input  logic      result_valid,
	input  logic      result_ready,
	input  out_item_t result_data,
	input  logic      cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	output int        mismatches,
	output int        outstanding
);

	// LCDC bit positions
	localparam int LCDC_BG      = 0;
	localparam int LCDC_OBJ     = 1;
	localparam int LCDC_BG_MAP  = 3;
	localparam int LCDC_TILE_U  = 4;
	localparam int LCDC_WIN     = 5;
	localparam int LCDC_WIN_MAP = 6;

	cfg_t        regs;
	logic [7:0]  cur_x;
	logic [2:0]  dropped;
	logic        win_fetched;
	logic [7:0]  cur_line;
	logic [7:0]  obj_xpos [SPRITE_SLOTS];
	logic [15:0] obj_attr [SPRITE_SLOTS];
	out_item_t   expected_q [$];
	int          errs = 0;

	assign mismatches = errs;

	function automatic out_item_t tile_fetch(logic map_hi, logic [7:0] row, logic [4:0] col);
		out_item_t f;
		f = '0;
		f.line_active    = 1'b1;
		f.action         = ACT_FETCH;
		f.map_row_addr   = (map_hi ? MAP_BASE_HI : MAP_BASE_LO) + 16'(row[7:3]) * 16'h20;
		f.tile_data_base = regs.lcdc_flags[LCDC_TILE_U] ? TDATA_UNSIGNED : TDATA_SIGNED;
		f.signed_tiles   = ~regs.lcdc_flags[LCDC_TILE_U];
		f.tile_col       = col;
		f.tile_row       = row[2:0];
		return f;
	endfunction

	// Apply one transaction to the line state; return 1 when it yields a result.
	function automatic bit decide_dot(input in_item_t it, output out_item_t r);
		bit         bg_on;
		bit         hit;
		logic [7:0] row;
		logic [3:0] skip;
		int         s;
		r = '0;
		r.line_active = 1'b1;
		bg_on = regs.colour_mode || regs.lcdc_flags[LCDC_BG];
		case (it.op)
			OP_LOAD: begin
				if (it.slot < SPRITE_SLOTS) begin
					obj_xpos[it.slot] = it.obj_x;
					obj_attr[it.slot] = it.obj_addr;
				end
				return 1'b0;
			end
			OP_START: begin
				cur_line    = it.line;
				cur_x       = 8'd0;
				dropped     = 3'd0;
				win_fetched = 1'b0;
				if (bg_on) begin
					row = regs.scroll_y + it.line;
					r = tile_fetch(regs.lcdc_flags[LCDC_BG_MAP], row, regs.scroll_x[7:3]);
				end else begin
					r.action = ACT_DISABLE;
				end
				return 1'b1;
			end
			OP_TICK: begin
				// past the line end: report done, leave state alone
				if (cur_x >= LINE_WIDTH) begin
					r.line_active = 1'b0;
					return 1'b1;
				end
				if (bg_on) begin
					if (it.fifo_count <= FIFO_MIN)
						return 1'b1;
					if (dropped < regs.scroll_x[2:0]) begin
						dropped = dropped + 3'd1;
						r.action = ACT_DROP;
						return 1'b1;
					end
					if (!win_fetched && regs.lcdc_flags[LCDC_WIN] && cur_line >= regs.window_y
							&& regs.window_x >= WX_OFFSET
							&& cur_x == regs.window_x - WX_OFFSET) begin
						win_fetched = 1'b1;
						row = cur_line - regs.window_y;
						r = tile_fetch(regs.lcdc_flags[LCDC_WIN_MAP], row, 5'd0);
						return 1'b1;
					end
					if (regs.lcdc_flags[LCDC_OBJ]) begin
						if (it.sprite_fetch_busy)
							return 1'b1;
						// lowest matching slot wins
						for (s = 0; s < SPRITE_SLOTS; s++) begin
							hit  = 1'b0;
							skip = 4'd0;
							if (obj_attr[s] != 16'h0) begin
								if (cur_x == 8'd0 && obj_xpos[s] < 8'd8) begin
									hit  = 1'b1;
									skip = 4'(8 - obj_xpos[s]);
								end else if (obj_xpos[s] >= 8'd8
										&& obj_xpos[s] - 8'd8 == cur_x) begin
									hit = 1'b1;
								end
							end
							if (hit) begin
								r.action      = ACT_SPRITE;
								r.sprite_slot = 4'(s);
								r.sprite_skip = skip;
								r.sprite_addr = obj_attr[s];
								obj_attr[s]   = 16'h0;
								obj_xpos[s]   = 8'h0;
								return 1'b1;
							end
						end
					end
				end
				r.action = ACT_PIXEL;
				cur_x = cur_x + 8'd1;
				if (cur_x == LINE_WIDTH)
					r.line_active = 1'b0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		out_item_t new_r;
		int        k;
		if (!arst_n) begin
			regs.lcdc_flags  = 8'h91;
			regs.scroll_x    = 8'h00;
			regs.scroll_y    = 8'h00;
			regs.window_y    = 8'h00;
			regs.window_x    = 8'h00;
			regs.colour_mode = 1'b0;
			cur_x       = 8'd0;
			dropped     = 3'd0;
			win_fetched = 1'b0;
			cur_line    = 8'd0;
			for (k = 0; k < SPRITE_SLOTS; k++) begin
				obj_xpos[k] = 8'h0;
				obj_attr[k] = 16'h0;
			end
			expected_q.delete();
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					$error("result transaction with nothing pending: action %0d",
						result_data.action);
					errs++;
				end else begin
					exp_r = expected_q.pop_front();
					check_field("line_active", 16'(exp_r.line_active),
						16'(result_data.line_active));
					check_field("action", 16'(exp_r.action), 16'(result_data.action));
					check_field("map_row_addr", exp_r.map_row_addr, result_data.map_row_addr);
					check_field("tile_data_base", exp_r.tile_data_base,
						result_data.tile_data_base);
					check_field("tile_col", 16'(exp_r.tile_col), 16'(result_data.tile_col));
					check_field("tile_row", 16'(exp_r.tile_row), 16'(result_data.tile_row));
					check_field("signed_tiles", 16'(exp_r.signed_tiles),
						16'(result_data.signed_tiles));
					check_field("sprite_slot", 16'(exp_r.sprite_slot),
						16'(result_data.sprite_slot));
					check_field("sprite_skip", 16'(exp_r.sprite_skip),
						16'(result_data.sprite_skip));
					check_field("sprite_addr", exp_r.sprite_addr, result_data.sprite_addr);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_LCDC:   regs.lcdc_flags  = cfg_wdata;
					CFG_SCX:    regs.scroll_x    = cfg_wdata;
					CFG_SCY:    regs.scroll_y    = cfg_wdata;
					CFG_WY:     regs.window_y    = cfg_wdata;
					CFG_WX:     regs.window_x    = cfg_wdata;
					CFG_COLOUR: regs.colour_mode = cfg_wdata[0];
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				if (decide_dot(item_data, new_r))
					expected_q.push_back(new_r);
			end
			outstanding <= expected_q.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import lpts_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         IDLE_LIMIT  = 2000;
	localparam int         ITEM_TARGET = 1700;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [7:0] cfg_wdata;
	int         mismatches;
	int         outstanding;
	int         produced     = 0;
	int         idle_cycles  = 0;
	int         result_stall = 0;
	bit         calm         = 1'b0;

	lpts_stream_if #(.item_t(in_item_t))  item_ch ();
	lpts_stream_if #(.item_t(out_item_t)) result_ch ();

	lcd_pixel_transfer_sequencer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	lpts_result_checker u_dot_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_ch.valid),
		.item_ready   (item_ch.ready),
		.item_data    (item_ch.data),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_data  (result_ch.data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side back-pressure in short bursts
	always @(posedge clk) begin
		if (calm) begin
			result_ch.ready <= 1'b1;
		end else if (result_stall > 0) begin
			result_ch.ready <= 1'b0;
			result_stall <= result_stall - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			result_ch.ready <= 1'b0;
			result_stall <= $urandom_range(0, 3);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic in_item_t noise_item();
		in_item_t it;
		it.op                = OP_TICK;
		it.slot              = 4'($urandom_range(0, 15));
		it.obj_x             = 8'($urandom);
		it.obj_addr          = 16'($urandom);
		it.line              = 8'($urandom);
		it.fifo_count        = 5'($urandom_range(0, 16));
		it.sprite_fetch_busy = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic in_item_t dot_tick(logic [4:0] fifo, logic busy);
		in_item_t it;
		it = noise_item();
		it.fifo_count        = fifo;
		it.sprite_fetch_busy = busy;
		return it;
	endfunction

	function automatic in_item_t sprite_load(logic [3:0] slot, logic [7:0] x, logic [15:0] addr);
		in_item_t it;
		it = noise_item();
		it.op       = OP_LOAD;
		it.slot     = slot;
		it.obj_x    = x;
		it.obj_addr = addr;
		return it;
	endfunction

	function automatic in_item_t line_start(logic [7:0] line);
		in_item_t it;
		it = noise_item();
		it.op   = OP_START;
		it.line = line;
		return it;
	endfunction

	function automatic cfg_t random_setting();
		cfg_t c;
		c.lcdc_flags = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) != 0)
			c.lcdc_flags = c.lcdc_flags | 8'h23;
		c.scroll_x    = 8'($urandom);
		c.scroll_y    = 8'($urandom);
		c.window_y    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 60));
		c.window_x    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 166));
		c.colour_mode = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Offer one transaction, with an occasional gap before it; return once accepted.
	task automatic push_item(input in_item_t it);
		if (!calm && $urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_ch.data  <= it;
		item_ch.valid <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		if (it.op == OP_START || it.op == OP_TICK)
			produced++;
	endtask

	// Hold the item side until every expected result is back, then let loads settle.
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		drain();
		put_reg(CFG_LCDC, c.lcdc_flags);
		put_reg(CFG_SCX, c.scroll_x);
		put_reg(CFG_SCY, c.scroll_y);
		put_reg(CFG_WY, c.window_y);
		put_reg(CFG_WX, c.window_x);
		put_reg(CFG_COLOUR, {7'd0, c.colour_mode});
		cfg_we <= 1'b0;
	endtask

	// Load sprites, start a line and tick through it, with some stray transactions.
	task automatic run_line(input bit hold_mid);
		in_item_t it;
		int       n_loads;
		int       n_ticks;
		int       k;
		n_loads = $urandom_range(2, 12);
		for (k = 0; k < n_loads; k++) begin
			it = sprite_load(($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
					: 4'($urandom_range(0, 9)),
				($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 167)),
				($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom));
			push_item(it);
		end
		push_item(line_start(8'($urandom)));
		n_ticks = $urandom_range(170, 260);
		for (k = 0; k < n_ticks; k++) begin
			if (hold_mid && k == 90)
				drain();
			if ($urandom_range(0, 24) == 0) begin
				it = noise_item();
				case ($urandom_range(0, 2))
					0: it.op = OP_LOAD;
					1: it.op = OP_START;
					default: it.op = OP_UNUSED;
				endcase
			end else begin
				it = dot_tick(($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 8))
						: 5'($urandom_range(9, 16)),
					($urandom_range(0, 9) == 0));
			end
			push_item(it);
		end
	endtask

	initial begin
		in_item_t it;
		cfg_t     setting;
		int       phase;
		int       k;
		arst_n          <= 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.data    <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= CFG_LCDC;
		cfg_wdata       <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick before any line start, then an unused op
		push_item(dot_tick(5'd16, 1'b0));
		it = noise_item();
		it.op = OP_UNUSED;
		push_item(it);
		push_item(sprite_load(4'd15, 8'd3, 16'hBEEF));
		push_item(sprite_load(4'd0, 8'd0, 16'hFFFF));
		push_item(sprite_load(4'd9, 8'd255, 16'h0001));
		push_item(sprite_load(4'd1, 8'd7, 16'h1234));
		push_item(sprite_load(4'd2, 8'd8, 16'h8000));

		setting = '{lcdc_flags: 8'hFF, scroll_x: 8'hFF, scroll_y: 8'hFF,
			window_y: 8'h00, window_x: 8'h07, colour_mode: 1'b0};
		program_regs(setting);
		push_item(line_start(8'hFF));
		push_item(dot_tick(5'd8, 1'b0));
		push_item(dot_tick(5'd0, 1'b0));
		for (k = 0; k < 7; k++)
			push_item(dot_tick(5'd16, 1'b0));
		// window fetch at the left edge, then a busy fetcher, then sprites
		push_item(dot_tick(5'd16, 1'b0));
		push_item(dot_tick(5'd16, 1'b1));
		for (k = 0; k < 4; k++)
			push_item(dot_tick(5'd16, 1'b0));

		setting = '{lcdc_flags: 8'h00, scroll_x: 8'h00, scroll_y: 8'h00,
			window_y: 8'h00, window_x: 8'h00, colour_mode: 1'b0};
		program_regs(setting);
		push_item(line_start(8'h00));
		push_item(dot_tick(5'd0, 1'b0));

		phase = 0;
		while (produced < ITEM_TARGET) begin
			case (phase)
				0: setting = '{lcdc_flags: 8'h00, scroll_x: 8'h00, scroll_y: 8'h00,
					window_y: 8'h00, window_x: 8'h00, colour_mode: 1'b1};
				1: setting = '{lcdc_flags: 8'hFF, scroll_x: 8'hFF, scroll_y: 8'hFF,
					window_y: 8'hFF, window_x: 8'hFF, colour_mode: 1'b1};
				2: setting = '{lcdc_flags: 8'h92, scroll_x: 8'h13, scroll_y: 8'h40,
					window_y: 8'h10, window_x: 8'h30, colour_mode: 1'b0};
				default: setting = random_setting();
			endcase
			program_regs(setting);
			if (produced >= ITEM_TARGET - 300)
				calm = 1'b1;
			run_line(phase == 3);
			phase++;
		end

		calm = 1'b1;
		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/lpts_pkg.sv
hw/rtl/lpts_stream_if.sv
hw/rtl/lpts_cfg_regs.sv
hw/rtl/lpts_sprite_table.sv
hw/rtl/lcd_pixel_transfer_sequencer_unit.sv
hw/rtl/lpts_checker.sv
test/lpts_result_checker.sv
test/tb_top.sv
